### rtl/erot_pkg.sv
// shared types and constants for the euler rotation block
`default_nettype none
package erot_pkg;

    localparam int NUM_POINTS_DEF     = 3;
    localparam int STEPS_PER_TURN_DEF = 5760;

    localparam int INDEX_W = 2;
    localparam int COORD_W = 32;
    localparam int STEP_W  = 14;
    localparam int SINE_W  = 15;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 16384;
    localparam int SINE_MAX   = 32767;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    localparam int ANGLES = 3;
    localparam logic [1:0] ANG_ROLL  = 2'd0;
    localparam logic [1:0] ANG_YAW   = 2'd1;
    localparam logic [1:0] ANG_PITCH = 2'd2;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_Z1     = 4'd3;
    localparam logic [ST_W-1:0] ST_Y1     = 4'd5;
    localparam logic [ST_W-1:0] ST_X1     = 4'd7;
    localparam logic [ST_W-1:0] ST_Z2     = 4'd9;
    localparam logic [ST_W-1:0] ST_X2     = 4'd11;
    localparam logic [ST_W-1:0] ST_ISSUES = 4'd12;
    localparam logic [ST_W-1:0] ST_DONE   = 4'd13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_WRAP,
        S_QUAD,
        S_ROM_LO,
        S_ROM_HI,
        S_TRIG,
        S_ROTATE
    } erot_state_t;

    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctl_t;

endpackage
`default_nettype wire

### rtl/erot_sin_rom.sv
// quarter-wave sine rom, q0.15 magnitudes built at elaboration, registered read
`default_nettype none
module erot_sin_rom
    import erot_pkg::*;
#(
    parameter int STEPS_PER_TURN = STEPS_PER_TURN_DEF
) (
    input  logic                                   clk,
    input  logic [$clog2(STEPS_PER_TURN + 1)-1:0]  addr,
    output logic [SINE_W-1:0]                      data
);

    localparam longint unsigned TURN      = STEPS_PER_TURN;
    localparam longint unsigned HALF_TURN = TURN / 2;

    logic [SINE_W-1:0] rom_c [0:STEPS_PER_TURN];
    logic [SINE_W-1:0] data_reg;

    for (genvar r = 0; r <= STEPS_PER_TURN; r++) begin : g_rom
        localparam longint unsigned XA = (HALF_PI_Q30 * 64'(r) + HALF_TURN) / TURN;
        localparam longint unsigned X2 = (XA * XA) >> 30;
        localparam longint unsigned T1 = ((XA * X2) >> 30) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
        localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
        localparam longint SUM = longint'(XA) - longint'(T1) + longint'(T2)
                                 - longint'(T3) + longint'(T4) - longint'(T5)
                                 + longint'(T6);
        localparam longint SPOS = (SUM < 0) ? 0 : SUM;
        localparam longint QV   = (SPOS + 16384) / 32768;
        localparam longint QS   = (QV > SINE_MAX) ? SINE_MAX : QV;
        assign rom_c[r] = SINE_W'(QS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_c[addr];
    end

    assign data = data_reg;

endmodule
`default_nettype wire

### rtl/erot_mac.sv
// shared multiply-accumulate unit with round to nearest and 32-bit saturation
`default_nettype none
module erot_mac
    import erot_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   ctl,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [COORD_W-1:0]  data,
    output logic signed [COORD_W-1:0]  result
);

    mac_ctl_t                  ctl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-COORD_W:0]    top_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * data;
        if (ctl_reg.valid)
        begin
            acc_reg <= (ctl_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
    end

    always_comb
    begin
        rounded  = acc_reg + ACC_W'(ROUND_HALF);
        shifted  = rounded >>> FRAC_SHIFT;
        top_bits = shifted[ACC_W-1:COORD_W-1];
        if (top_bits == '0 || top_bits == '1)
        begin
            result = shifted[COORD_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            result = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

### rtl/euler_rotate_three_points.sv
// top level: sequencer, point and angle storage, output register
// load: the point is stored when the request is taken, then echoed into the output register once it is free
// rotate: per angle wrap, quadrant, two rom reads and trig (wrap repeats once per full turn added to
// or taken off a step), then each point runs the schedule through the one shared 16x32 multiplier
// the input stalls until the last point is in the output register
// reset clears points and accumulated angles to zero at once, no sweep
`default_nettype none
module euler_rotate_three_points
    import erot_pkg::*;
#(
    parameter int NUM_POINTS     = NUM_POINTS_DEF,
    parameter int STEPS_PER_TURN = STEPS_PER_TURN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [INDEX_W-1:0]                  point_index,
    input  logic signed [COORD_W-1:0]           load_x,
    input  logic signed [COORD_W-1:0]           load_y,
    input  logic signed [COORD_W-1:0]           load_z,
    input  logic signed [STEP_W-1:0]            roll_step,
    input  logic signed [STEP_W-1:0]            yaw_step,
    input  logic signed [STEP_W-1:0]            pitch_step,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [INDEX_W-1:0]                  out_index,
    output logic signed [COORD_W-1:0]           out_x,
    output logic signed [COORD_W-1:0]           out_y,
    output logic signed [COORD_W-1:0]           out_z,
    output logic [$clog2(STEPS_PER_TURN)-1:0]   roll_total,
    output logic [$clog2(STEPS_PER_TURN)-1:0]   yaw_total,
    output logic [$clog2(STEPS_PER_TURN)-1:0]   pitch_total,
    output logic                                last_point
);

    localparam int ANG_W   = $clog2(STEPS_PER_TURN);
    localparam int RADDR_W = $clog2(STEPS_PER_TURN + 1);
    localparam int RED_W   = ((ANG_W > STEP_W) ? ANG_W : STEP_W) + 2;
    localparam int U_W     = ANG_W + 2;
    localparam int PIDX_W  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    localparam logic signed [RED_W-1:0] TURN_R  = RED_W'(STEPS_PER_TURN);
    localparam logic [ANG_W:0]          TURN_T  = (ANG_W + 1)'(STEPS_PER_TURN);
    localparam logic [U_W-1:0]          TURN_U1 = U_W'(STEPS_PER_TURN);
    localparam logic [U_W-1:0]          TURN_U2 = U_W'(2 * STEPS_PER_TURN);
    localparam logic [U_W-1:0]          TURN_U3 = U_W'(3 * STEPS_PER_TURN);
    localparam logic [RADDR_W-1:0]      TURN_A  = RADDR_W'(STEPS_PER_TURN);
    localparam logic [PIDX_W-1:0]       PIDX_LAST = PIDX_W'(NUM_POINTS - 1);

    erot_state_t state_reg, state_next;

    logic [1:0]               ang_reg;
    logic [1:0]               ang_next;
    logic [ST_W-1:0]          st_reg;
    logic [PIDX_W-1:0]        pidx_reg;

    logic signed [STEP_W-1:0] step_reg  [0:ANGLES-1];
    logic [ANG_W-1:0]         total_reg [0:ANGLES-1];
    logic signed [COEF_W-1:0] sin_reg   [0:ANGLES-1];
    logic signed [COEF_W-1:0] cos_reg   [0:ANGLES-1];
    logic signed [RED_W-1:0]  red_reg;
    logic [1:0]               quad_reg;
    logic [ANG_W-1:0]         r_reg;
    logic [SINE_W-1:0]        lo_reg;

    logic signed [COORD_W-1:0] px_reg [0:NUM_POINTS-1];
    logic signed [COORD_W-1:0] py_reg [0:NUM_POINTS-1];
    logic signed [COORD_W-1:0] pz_reg [0:NUM_POINTS-1];

    logic signed [COORD_W-1:0] z1_reg, y1_reg, x1_reg, z2_reg, x2_reg;

    logic                      out_valid_reg;
    logic [INDEX_W-1:0]        out_index_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [ANG_W-1:0]          out_total_reg [0:ANGLES-1];
    logic                      out_last_reg;

    logic                      out_free;
    logic                      out_load;
    logic                      load_ok;
    logic                      wrap_done;
    logic                      rot_done;
    logic                      last_pt;

    logic [ANG_W-1:0]          m_c;
    logic [ANG_W:0]            tsum_c;
    logic [ANG_W-1:0]          total_c;
    logic [U_W-1:0]            u_c;
    logic [1:0]                quad_c;
    logic [ANG_W-1:0]          r_c;

    logic [RADDR_W-1:0]        rom_addr;
    logic [SINE_W-1:0]         rom_q;
    logic signed [COEF_W-1:0]  lo_c, hi_c, sin_c, cos_c;

    mac_ctl_t                  mac_ctl;
    logic signed [COEF_W-1:0]  mac_coef;
    logic signed [COORD_W-1:0] mac_data;
    logic signed [COORD_W-1:0] mac_res;
    logic signed [COORD_W-1:0] cur_x, cur_y, cur_z;

    erot_sin_rom #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    erot_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (mac_coef),
        .data   (mac_data),
        .result (mac_res)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign load_ok   = int'(point_index) < NUM_POINTS;
    assign wrap_done = !red_reg[RED_W-1] && (red_reg < TURN_R);
    assign last_pt   = (pidx_reg == PIDX_LAST);
    assign rot_done  = (state_reg == S_ROTATE) && (st_reg == ST_DONE) && out_free;
    assign out_load  = ((state_reg == S_ECHO) && out_free) || rot_done;
    assign ang_next  = (ang_reg == ANG_PITCH) ? ANG_ROLL : ang_reg + 2'd1;

    assign cur_x = px_reg[pidx_reg];
    assign cur_y = py_reg[pidx_reg];
    assign cur_z = pz_reg[pidx_reg];

    // angle reduction and quadrant split
    always_comb
    begin
        m_c     = red_reg[ANG_W-1:0];
        tsum_c  = {1'b0, total_reg[ang_reg]} + {1'b0, m_c};
        total_c = (tsum_c >= TURN_T) ? ANG_W'(tsum_c - TURN_T) : tsum_c[ANG_W-1:0];
        u_c     = {m_c, 2'b00};
        if (u_c >= TURN_U3)
        begin
            quad_c = 2'd3;
            r_c    = ANG_W'(u_c - TURN_U3);
        end
        else if (u_c >= TURN_U2)
        begin
            quad_c = 2'd2;
            r_c    = ANG_W'(u_c - TURN_U2);
        end
        else if (u_c >= TURN_U1)
        begin
            quad_c = 2'd1;
            r_c    = ANG_W'(u_c - TURN_U1);
        end
        else
        begin
            quad_c = 2'd0;
            r_c    = u_c[ANG_W-1:0];
        end
    end

    // sine and cosine from the two rom reads
    always_comb
    begin
        lo_c = {1'b0, lo_reg};
        hi_c = {1'b0, rom_q};
        case (quad_reg)
            2'd0:
            begin
                sin_c = lo_c;
                cos_c = hi_c;
            end
            2'd1:
            begin
                sin_c = hi_c;
                cos_c = -lo_c;
            end
            2'd2:
            begin
                sin_c = -lo_c;
                cos_c = -hi_c;
            end
            default:
            begin
                sin_c = -hi_c;
                cos_c = lo_c;
            end
        endcase
    end

    // multiplier schedule for one point
    always_comb
    begin
        mac_ctl.valid = (state_reg == S_ROTATE) && (st_reg < ST_ISSUES);
        mac_ctl.first = !st_reg[0];
        case (st_reg)
            4'd0:
            begin
                mac_coef = sin_reg[ANG_ROLL];
                mac_data = cur_y;
            end
            4'd1:
            begin
                mac_coef = cos_reg[ANG_ROLL];
                mac_data = cur_z;
            end
            4'd2:
            begin
                mac_coef = cos_reg[ANG_ROLL];
                mac_data = cur_y;
            end
            4'd3:
            begin
                mac_coef = -sin_reg[ANG_ROLL];
                mac_data = cur_z;
            end
            4'd4:
            begin
                mac_coef = cos_reg[ANG_YAW];
                mac_data = cur_x;
            end
            4'd5:
            begin
                mac_coef = sin_reg[ANG_YAW];
                mac_data = z1_reg;
            end
            4'd6:
            begin
                mac_coef = -sin_reg[ANG_YAW];
                mac_data = cur_x;
            end
            4'd7:
            begin
                mac_coef = cos_reg[ANG_YAW];
                mac_data = z1_reg;
            end
            4'd8:
            begin
                mac_coef = cos_reg[ANG_PITCH];
                mac_data = x1_reg;
            end
            4'd9:
            begin
                mac_coef = -sin_reg[ANG_PITCH];
                mac_data = y1_reg;
            end
            4'd10:
            begin
                mac_coef = sin_reg[ANG_PITCH];
                mac_data = x1_reg;
            end
            4'd11:
            begin
                mac_coef = cos_reg[ANG_PITCH];
                mac_data = y1_reg;
            end
            default:
            begin
                mac_coef = '0;
                mac_data = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        rom_addr   = RADDR_W'(r_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        if (load_ok)
                        begin
                            state_next = S_ECHO;
                        end
                    end
                    else
                    begin
                        state_next = S_WRAP;
                    end
                end
            end
            S_ECHO:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRAP:
            begin
                if (wrap_done)
                begin
                    state_next = S_QUAD;
                end
            end
            S_QUAD:
            begin
                state_next = S_ROM_LO;
            end
            S_ROM_LO:
            begin
                state_next = S_ROM_HI;
            end
            S_ROM_HI:
            begin
                rom_addr   = TURN_A - RADDR_W'(r_reg);
                state_next = S_TRIG;
            end
            S_TRIG:
            begin
                state_next = (ang_reg == ANG_PITCH) ? S_ROTATE : S_WRAP;
            end
            S_ROTATE:
            begin
                if (rot_done && last_pt)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ang_reg       <= ANG_ROLL;
            st_reg        <= '0;
            pidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < ANGLES; a++)
            begin
                total_reg[a] <= '0;
            end
            for (int p = 0; p < NUM_POINTS; p++)
            begin
                px_reg[p] <= '0;
                py_reg[p] <= '0;
                pz_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    ang_reg <= ANG_ROLL;
                    if (in_valid && opcode == OP_LOAD && load_ok)
                    begin
                        pidx_reg                         <= PIDX_W'(point_index);
                        px_reg[PIDX_W'(point_index)]     <= load_x;
                        py_reg[PIDX_W'(point_index)]     <= load_y;
                        pz_reg[PIDX_W'(point_index)]     <= load_z;
                    end
                end
                S_QUAD:
                begin
                    total_reg[ang_reg] <= total_c;
                end
                S_TRIG:
                begin
                    ang_reg  <= ang_next;
                    st_reg   <= '0;
                    pidx_reg <= '0;
                end
                S_ROTATE:
                begin
                    if (st_reg != ST_DONE)
                    begin
                        st_reg <= st_reg + 4'd1;
                    end
                    else if (out_free)
                    begin
                        px_reg[pidx_reg] <= x2_reg;
                        py_reg[pidx_reg] <= mac_res;
                        pz_reg[pidx_reg] <= z2_reg;
                        st_reg           <= '0;
                        if (!last_pt)
                        begin
                            pidx_reg <= pidx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                step_reg[ANG_ROLL]  <= roll_step;
                step_reg[ANG_YAW]   <= yaw_step;
                step_reg[ANG_PITCH] <= pitch_step;
                red_reg             <= RED_W'(roll_step);
            end
            S_WRAP:
            begin
                if (red_reg[RED_W-1])
                begin
                    red_reg <= red_reg + TURN_R;
                end
                else if (!wrap_done)
                begin
                    red_reg <= red_reg - TURN_R;
                end
            end
            S_QUAD:
            begin
                quad_reg <= quad_c;
                r_reg    <= r_c;
            end
            S_ROM_HI:
            begin
                lo_reg <= rom_q;
            end
            S_TRIG:
            begin
                sin_reg[ang_reg] <= sin_c;
                cos_reg[ang_reg] <= cos_c;
                red_reg          <= RED_W'(step_reg[ang_next]);
            end
            S_ROTATE:
            begin
                if (st_reg == ST_Z1)
                begin
                    z1_reg <= mac_res;
                end
                if (st_reg == ST_Y1)
                begin
                    y1_reg <= mac_res;
                end
                if (st_reg == ST_X1)
                begin
                    x1_reg <= mac_res;
                end
                if (st_reg == ST_Z2)
                begin
                    z2_reg <= mac_res;
                end
                if (st_reg == ST_X2)
                begin
                    x2_reg <= mac_res;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= INDEX_W'(pidx_reg);
            for (int a = 0; a < ANGLES; a++)
            begin
                out_total_reg[a] <= total_reg[a];
            end
            if (state_reg == S_ECHO)
            begin
                out_x_reg    <= cur_x;
                out_y_reg    <= cur_y;
                out_z_reg    <= cur_z;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_x_reg    <= x2_reg;
                out_y_reg    <= mac_res;
                out_z_reg    <= z2_reg;
                out_last_reg <= last_pt;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign roll_total  = out_total_reg[ANG_ROLL];
    assign yaw_total   = out_total_reg[ANG_YAW];
    assign pitch_total = out_total_reg[ANG_PITCH];
    assign last_point  = out_last_reg;

endmodule
`default_nettype wire

### dv/euler_rotate_three_points_test.sv
// self-checking testbench for the euler rotation block: queued requests, predicted point reports
`default_nettype none
module euler_rotate_three_points_test;
    import erot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TURN         = STEPS_PER_TURN_DEF;
    localparam int NPTS         = NUM_POINTS_DEF;
    localparam int TOT_W        = $clog2(STEPS_PER_TURN_DEF);
    localparam int RANDOM_ITEMS = 480;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic                      opcode;
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [STEP_W-1:0]  roll;
        logic signed [STEP_W-1:0]  yaw;
        logic signed [STEP_W-1:0]  pitch;
        bit                        hold;
    } point_request_t;

    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TOT_W-1:0]          roll;
        logic [TOT_W-1:0]          yaw;
        logic [TOT_W-1:0]          pitch;
        logic                      last;
    } point_report_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      opcode = OP_LOAD;
    logic [INDEX_W-1:0]        point_index = '0;
    logic signed [COORD_W-1:0] load_x = '0;
    logic signed [COORD_W-1:0] load_y = '0;
    logic signed [COORD_W-1:0] load_z = '0;
    logic signed [STEP_W-1:0]  roll_step = '0;
    logic signed [STEP_W-1:0]  yaw_step = '0;
    logic signed [STEP_W-1:0]  pitch_step = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [INDEX_W-1:0]        out_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [TOT_W-1:0]          roll_total;
    logic [TOT_W-1:0]          yaw_total;
    logic [TOT_W-1:0]          pitch_total;
    logic                      last_point;

    point_request_t pending_requests[$];
    point_report_t  expected_reports[$];
    point_request_t sent_req;
    point_report_t  seen_report;

    int sine_lut[0:TURN];
    logic signed [COORD_W-1:0] pos_x[NPTS];
    logic signed [COORD_W-1:0] pos_y[NPTS];
    logic signed [COORD_W-1:0] pos_z[NPTS];
    int ang_roll;
    int ang_yaw;
    int ang_pitch;

    int requests_sent;
    int reports_seen;
    int failures;
    int quiet_cycles;

    euler_rotate_three_points uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .point_index(point_index),
        .load_x     (load_x),
        .load_y     (load_y),
        .load_z     (load_z),
        .roll_step  (roll_step),
        .yaw_step   (yaw_step),
        .pitch_step (pitch_step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .roll_total (roll_total),
        .yaw_total  (yaw_total),
        .pitch_total(pitch_total),
        .last_point (last_point)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int quarter_sine(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        x = (HALF_PI_Q30 * r + longint'(TURN / 2)) / longint'(TURN);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (sum + ROUND_HALF) / 32768;
        if (q > SINE_MAX)
            q = SINE_MAX;
        return int'(q);
    endfunction

    function automatic int wrap_turn(int a);
        int m;
        m = a % TURN;
        if (m < 0)
            m = m + TURN;
        return m;
    endfunction

    function automatic void sin_cos_of(input int a, output int s, output int c);
        int u;
        int r;
        int lo;
        int hi;
        u = 4 * wrap_turn(a);
        r = u % TURN;
        lo = sine_lut[r];
        hi = sine_lut[TURN - r];
        case (u / TURN)
            0: begin s = lo; c = hi; end
            1: begin s = hi; c = -lo; end
            2: begin s = -lo; c = -hi; end
            default: begin s = -hi; c = lo; end
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] rot_mac(int c1, logic signed [COORD_W-1:0] u,
                                                          int c2, logic signed [COORD_W-1:0] v);
        longint w;
        w = longint'(c1) * longint'(u) + longint'(c2) * longint'(v) + ROUND_HALF;
        w = w >>> FRAC_SHIFT;
        if (w > 64'sd2147483647)
            w = 64'sd2147483647;
        if (w < -64'sd2147483648)
            w = -64'sd2147483648;
        return w[COORD_W-1:0];
    endfunction

    function automatic point_report_t report_of(int idx, bit last);
        point_report_t rep;
        rep.index = idx[INDEX_W-1:0];
        rep.x = pos_x[idx];
        rep.y = pos_y[idx];
        rep.z = pos_z[idx];
        rep.roll = ang_roll[TOT_W-1:0];
        rep.yaw = ang_yaw[TOT_W-1:0];
        rep.pitch = ang_pitch[TOT_W-1:0];
        rep.last = last;
        return rep;
    endfunction

    task automatic predict_reports(point_request_t req);
        int sr, cr, sy, cy, sp, cp;
        logic signed [COORD_W-1:0] x, y, z, z1, y1, x1;
        if (req.opcode == OP_LOAD)
        begin
            if (req.index < NPTS)
            begin
                pos_x[req.index] = req.x;
                pos_y[req.index] = req.y;
                pos_z[req.index] = req.z;
                expected_reports.push_back(report_of(req.index, 1'b1));
            end
        end
        else
        begin
            ang_roll = wrap_turn(ang_roll + int'(req.roll));
            ang_yaw = wrap_turn(ang_yaw + int'(req.yaw));
            ang_pitch = wrap_turn(ang_pitch + int'(req.pitch));
            sin_cos_of(int'(req.roll), sr, cr);
            sin_cos_of(int'(req.yaw), sy, cy);
            sin_cos_of(int'(req.pitch), sp, cp);
            for (int i = 0; i < NPTS; i++)
            begin
                x = pos_x[i];
                y = pos_y[i];
                z = pos_z[i];
                z1 = rot_mac(sr, y, cr, z);
                y1 = rot_mac(cr, y, -sr, z);
                x1 = rot_mac(cy, x, sy, z1);
                pos_z[i] = rot_mac(-sy, x, cy, z1);
                pos_x[i] = rot_mac(cp, x1, -sp, y1);
                pos_y[i] = rot_mac(sp, x1, cp, y1);
                expected_reports.push_back(report_of(i, i == NPTS - 1));
            end
        end
    endtask

    task automatic compare_report(point_report_t got);
        point_report_t want;
        if (expected_reports.size() == 0)
        begin
            failures++;
            if (failures <= SHOWN_ERRORS)
                $display("unexpected report: idx %0d x %h y %h z %h angles %0d %0d %0d last %0d",
                         got.index, got.x, got.y, got.z, got.roll, got.yaw, got.pitch, got.last);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (got.index !== want.index || got.x !== want.x || got.y !== want.y
                || got.z !== want.z || got.roll !== want.roll || got.yaw !== want.yaw
                || got.pitch !== want.pitch || got.last !== want.last)
            begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                begin
                    $display("mismatch  got: idx %0d x %h y %h z %h angles %0d %0d %0d last %0d",
                             got.index, got.x, got.y, got.z, got.roll, got.yaw, got.pitch,
                             got.last);
                    $display("      wanted: idx %0d x %h y %h z %h angles %0d %0d %0d last %0d",
                             want.index, want.x, want.y, want.z, want.roll, want.yaw,
                             want.pitch, want.last);
                end
            end
        end
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int choice;
        choice = $urandom_range(0, 9);
        case (choice)
            0: return $urandom();
            1: return $urandom_range(0, 32) - 16;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return 0;
                    1: return TURN / 4;
                    2: return TURN / 2;
                    3: return 3 * TURN / 4;
                    4: return TURN - 1;
                    default: return 1 - TURN;
                endcase
            end
            default: return $urandom_range(0, 2 * TURN - 2) - (TURN - 1);
        endcase
    endfunction

    task automatic queue_load(int idx, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z, bit hold);
        point_request_t req;
        req.opcode = OP_LOAD;
        req.index = idx[INDEX_W-1:0];
        req.x = x;
        req.y = y;
        req.z = z;
        req.roll = pick_step();
        req.yaw = pick_step();
        req.pitch = pick_step();
        req.hold = hold;
        pending_requests.push_back(req);
    endtask

    task automatic queue_rotate(int r, int y, int p, bit hold);
        point_request_t req;
        req.opcode = OP_ROTATE;
        req.index = $urandom_range(0, 3);
        req.x = pick_coord();
        req.y = pick_coord();
        req.z = pick_coord();
        req.roll = r[STEP_W-1:0];
        req.yaw = y[STEP_W-1:0];
        req.pitch = p[STEP_W-1:0];
        req.hold = hold;
        pending_requests.push_back(req);
    endtask

    // driver: one request in flight, held steady while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            requests_sent <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_reports(sent_req);
                requests_sent <= requests_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0
                    && !(pending_requests[0].hold && expected_reports.size() > 0)
                    && ((requests_sent >= 200 && requests_sent < 290)
                        || $urandom_range(0, 99) >= 21))
                begin
                    sent_req = pending_requests.pop_front();
                    opcode <= sent_req.opcode;
                    point_index <= sent_req.index;
                    load_x <= sent_req.x;
                    load_y <= sent_req.y;
                    load_z <= sent_req.z;
                    roll_step <= sent_req.roll;
                    yaw_step <= sent_req.yaw;
                    pitch_step <= sent_req.pitch;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, every accepted report checked in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            reports_seen <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                seen_report.index = out_index;
                seen_report.x = out_x;
                seen_report.y = out_y;
                seen_report.z = out_z;
                seen_report.roll = roll_total;
                seen_report.yaw = yaw_total;
                seen_report.pitch = pitch_total;
                seen_report.last = last_point;
                compare_report(seen_report);
                reports_seen <= reports_seen + 1;
            end
            out_stall <= !(reports_seen >= 400 && reports_seen < 600)
                         && $urandom_range(0, 99) < 21;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int added;
        int choice;
        failures = 0;
        ang_roll = 0;
        ang_yaw = 0;
        ang_pitch = 0;
        for (int i = 0; i < NPTS; i++)
        begin
            pos_x[i] = '0;
            pos_y[i] = '0;
            pos_z[i] = '0;
        end
        for (int r = 0; r <= TURN; r++)
            sine_lut[r] = quarter_sine(r);

        // directed: extremes, wraps, quadrant edges, ignored index, out-of-range steps
        queue_rotate(0, 0, 0, 1'b0);
        queue_load(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        queue_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_load(2, 32'h0001_0000, 32'h8000_0000, 32'h1234_5678, 1'b0);
        queue_load(3, 32'hdead_beef, 32'h0bad_f00d, 32'h5555_aaaa, 1'b0);
        queue_rotate(TURN / 8, TURN / 8, TURN / 8, 1'b0);
        queue_rotate(TURN - 1, TURN - 1, TURN - 1, 1'b0);
        queue_rotate(1 - TURN, 1 - TURN, 1 - TURN, 1'b0);
        queue_rotate(-1, -1, -1, 1'b0);
        queue_rotate(8191, -8192, 0, 1'b0);
        queue_rotate(TURN / 4, TURN / 2, 3 * TURN / 4, 1'b0);
        queue_rotate(TURN / 2, 3 * TURN / 4, TURN / 4, 1'b0);
        queue_load(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_load(1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
        queue_rotate(1, -1, TURN, 1'b0);
        queue_rotate(-TURN, TURN, -8192, 1'b0);
        queue_rotate(-8192, 8191, -8192, 1'b0);
        queue_load(2, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001, 1'b0);
        queue_rotate(TURN / 6, -TURN / 6, 3000, 1'b0);

        // random: point reloads mixed with rotations, with some ignored loads
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 19);
            if (choice == 0)
                queue_load(3, pick_coord(), pick_coord(), pick_coord(), 1'b0);
            else if (choice < 9)
            begin
                queue_load($urandom_range(0, NPTS - 1), pick_coord(), pick_coord(),
                           pick_coord(), added % 64 == 63);
                added++;
            end
            else
            begin
                queue_rotate(int'($signed(pick_step())), int'($signed(pick_step())),
                             int'($signed(pick_step())), added % 64 == 63);
                added++;
            end
        end

        @(posedge clk);
        @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && expected_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
